[src/ira_pkg.sv]
// Shared definitions for the interval range ALU: opcodes, Q32.32 constants,
// pipeline depth figures, divider lane types and the 64-bit saturation helper.
// No dependencies.
package ira_pkg;

	localparam int IRA_CMD_W = 4;
	localparam logic [IRA_CMD_W-1:0] CMD_ADD  = 4'd0;
	localparam logic [IRA_CMD_W-1:0] CMD_SUB  = 4'd1;
	localparam logic [IRA_CMD_W-1:0] CMD_MUL  = 4'd2;
	localparam logic [IRA_CMD_W-1:0] CMD_DIV  = 4'd3;
	localparam logic [IRA_CMD_W-1:0] CMD_REM  = 4'd4;
	localparam logic [IRA_CMD_W-1:0] CMD_SHL  = 4'd5;
	localparam logic [IRA_CMD_W-1:0] CMD_ASHR = 4'd6;
	localparam logic [IRA_CMD_W-1:0] CMD_NEG  = 4'd7;
	localparam logic [IRA_CMD_W-1:0] CMD_EQ   = 4'd8;
	localparam logic [IRA_CMD_W-1:0] CMD_GT   = 4'd9;
	localparam logic [IRA_CMD_W-1:0] CMD_GE   = 4'd10;
	localparam logic [IRA_CMD_W-1:0] CMD_LT   = 4'd11;
	localparam logic [IRA_CMD_W-1:0] CMD_LE   = 4'd12;
	localparam logic [IRA_CMD_W-1:0] CMD_NE   = 4'd13;

	localparam logic signed [63:0] IRA_MIN = {1'b1, 63'd0};
	localparam logic signed [63:0] IRA_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] IRA_ONE = 64'sh0000_0001_0000_0000;

	localparam logic [15:0] IRA_EPS_RESET = 16'd43;

	// Four corner operations per interval product or quotient.
	localparam int IRA_CORNERS = 4;
	// Dividend is the 64-bit magnitude shifted up by 32 fraction bits.
	localparam int IRA_QW = 96;
	localparam int IRA_DIV_RADIX = 2;
	localparam int IRA_DIV_ITERS = IRA_QW / IRA_DIV_RADIX;
	localparam int IRA_DIV_FIRST = 3;
	localparam int IRA_MUL_DONE = 8;
	localparam int IRA_NSTG = IRA_DIV_FIRST + IRA_DIV_ITERS + 1;

	typedef struct packed {
		logic [63:0] un;
		logic [63:0] ud;
		logic        neg;
	} div_op_t;

	typedef struct packed {
		logic signed [63:0] lo;
		logic signed [63:0] hi;
	} div_bnd_t;

	function automatic logic signed [63:0] sat_s128(input logic signed [127:0] v);
		if (v[127:63] == '0 || v[127:63] == '1)
			return v[63:0];
		return v[127] ? IRA_MIN : IRA_MAX;
	endfunction

endpackage

[src/ira_div.sv]
// Pipelined radix-4 restoring divider for the four corner quotients of an
// interval division, with floor/ceil rounding and saturation at the end.
// Depends on ira_pkg.
module ira_div (
	input  logic                              clk,
	input  logic [ira_pkg::IRA_DIV_ITERS:0]   en,
	input  ira_pkg::div_op_t                  op_in  [ira_pkg::IRA_CORNERS],
	output ira_pkg::div_bnd_t                 bnd_out [ira_pkg::IRA_CORNERS]
);
	import ira_pkg::*;

	typedef struct packed {
		logic [63:0]        r;
		logic [IRA_QW-1:0]  w;
	} div_st_t;

	// The partial remainder stays below the divisor, so 64 bits hold it; the
	// work word shifts dividend bits out at the top and quotient bits in below.
	function automatic div_st_t div_step(input div_st_t s, input logic [63:0] ud);
		logic [64:0] t;
		div_st_t     o;
		o = s;
		for (int i = 0; i < IRA_DIV_RADIX; i++) begin
			t = {o.r, o.w[IRA_QW-1]};
			o.w = {o.w[IRA_QW-2:0], 1'b0};
			if (t >= {1'b0, ud}) begin
				o.r = 64'(t - {1'b0, ud});
				o.w[0] = 1'b1;
			end else begin
				o.r = t[63:0];
			end
		end
		return o;
	endfunction

	div_st_t     st_sd  [IRA_DIV_ITERS][IRA_CORNERS];
	logic [63:0] ud_sd  [IRA_DIV_ITERS][IRA_CORNERS];
	logic        neg_sd [IRA_DIV_ITERS][IRA_CORNERS];
	div_bnd_t    bnd_s51 [IRA_CORNERS];

	for (genvar gk = 0; gk < IRA_DIV_ITERS; gk++) begin : g_iter
		for (genvar gc = 0; gc < IRA_CORNERS; gc++) begin : g_corner
			div_st_t     st_in;
			logic [63:0] ud_in;
			logic        neg_in;
			if (gk == 0) begin : g_head
				assign st_in  = '{r: 64'd0, w: {op_in[gc].un, 32'd0}};
				assign ud_in  = op_in[gc].ud;
				assign neg_in = op_in[gc].neg;
			end else begin : g_body
				assign st_in  = st_sd[gk-1][gc];
				assign ud_in  = ud_sd[gk-1][gc];
				assign neg_in = neg_sd[gk-1][gc];
			end
			always_ff @(posedge clk) begin
				if (en[gk]) begin
					st_sd[gk][gc]  <= div_step(st_in, ud_in);
					ud_sd[gk][gc]  <= ud_in;
					neg_sd[gk][gc] <= neg_in;
				end
			end
		end
	end

	for (genvar gc = 0; gc < IRA_CORNERS; gc++) begin : g_fin
		logic [IRA_QW+1:0] q_ext;
		logic [IRA_QW+1:0] q_up;
		logic [IRA_QW+1:0] fl;
		logic [IRA_QW+1:0] cl;
		always_comb begin
			q_ext = {2'b00, st_sd[IRA_DIV_ITERS-1][gc].w};
			q_up  = q_ext + (IRA_QW+2)'(|st_sd[IRA_DIV_ITERS-1][gc].r);
			// A negative quotient rounds down by growing its magnitude.
			if (neg_sd[IRA_DIV_ITERS-1][gc]) begin
				fl = (IRA_QW+2)'(0) - q_up;
				cl = (IRA_QW+2)'(0) - q_ext;
			end else begin
				fl = q_ext;
				cl = q_up;
			end
		end
		always_ff @(posedge clk) begin
			if (en[IRA_DIV_ITERS]) begin
				bnd_s51[gc].lo <= sat_s128(128'($signed(fl)));
				bnd_s51[gc].hi <= sat_s128(128'($signed(cl)));
			end
		end
		assign bnd_out[gc] = bnd_s51[gc];
	end

endmodule

[src/interval_range_alu.sv]
// Top level of the interval range ALU: input decode, simple interval ops,
// pipelined interval multiply, divider hookup and output stage.
// Depends on ira_pkg and ira_div.
//
// Usage: each beat on the s_t* channel carries one opcode and two operand
// intervals in signed Q32.32; the block returns one beat on m_t* holding the
// bounding interval [res_lo, res_hi], saturated to 64 bits. Beats leave in
// the order they came in.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the
// division epsilon; it is always ready and should only be written while the
// pipeline holds no beats. Reset sets it to 43 LSBs.
// Every opcode passes through the same stages from input beat to output beat;
// the 48 radix-4 stages of the divider set that depth. Throughput is one beat
// per cycle while m_tready is high.
// Every stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stalled receiver backs the pipeline up one stage
// at a time and empty slots are squeezed out; s_tready drops only when every
// stage is full. Reset empties all stages.
module interval_range_alu (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data,   // div_epsilon
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [263:0] s_tdata,    // cmd, a_lo, a_hi, b_lo, b_hi, zero pad
	input  logic         s_tuser,    // same_operand
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata     // res_lo, res_hi
);
	import ira_pkg::*;

	localparam logic [1:0] TRI_NEVER  = 2'd0;
	localparam logic [1:0] TRI_ALWAYS = 2'd1;
	localparam logic [1:0] TRI_MAYBE  = 2'd2;

	function automatic logic signed [63:0] sneg(input logic signed [63:0] x);
		return (x == IRA_MIN) ? IRA_MAX : -x;
	endfunction

	function automatic logic signed [63:0] smin(input logic signed [63:0] x,
			input logic signed [63:0] y);
		return (x < y) ? x : y;
	endfunction

	function automatic logic signed [63:0] smax(input logic signed [63:0] x,
			input logic signed [63:0] y);
		return (x > y) ? x : y;
	endfunction

	function automatic logic signed [63:0] rmax_pos(input logic signed [63:0] ah,
			input logic signed [63:0] bh);
		return (ah >= bh) ? sat_s128(128'(bh) - 128'(IRA_ONE)) : ah;
	endfunction

	// Lower remainder bound once the divisor interval is non-negative.
	function automatic logic signed [63:0] rmin_nb(input logic signed [63:0] al,
			input logic signed [63:0] ah, input logic signed [63:0] bl,
			input logic signed [63:0] bh);
		logic signed [63:0] t;
		t = sneg(rmax_pos(sneg(al), bh));
		if (al >= 64'sd0)
			return (al != 64'sd0 && ah != 64'sd0 && ah < bl) ? al : 64'sd0;
		if (ah < 64'sd0)
			return t;
		return smin(t, 64'sd0);
	endfunction

	function automatic logic signed [63:0] rem_min(input logic signed [63:0] al,
			input logic signed [63:0] ah, input logic signed [63:0] bl,
			input logic signed [63:0] bh);
		if (bh < 64'sd0 && bl < 64'sd0)
			return rmin_nb(al, ah, sneg(bh), sneg(bl));
		if (bl < 64'sd0)
			return smin(rmin_nb(al, ah, IRA_ONE, sneg(bl)), rmin_nb(al, ah, 64'sd0, bh));
		return rmin_nb(al, ah, bl, bh);
	endfunction

	function automatic logic signed [63:0] rem_max(input logic signed [63:0] al,
			input logic signed [63:0] ah, input logic signed [63:0] bl,
			input logic signed [63:0] bh);
		if (al < 64'sd0 && ah < 64'sd0)
			return sneg(rem_min(sneg(ah), sneg(al), bl, bh));
		return rmax_pos(ah, bh);
	endfunction

	// Integer part truncated toward zero; fits 33 bits.
	function automatic logic signed [32:0] int_part(input logic signed [63:0] x);
		logic [63:0] m;
		m = 64'd0 - x;
		if (x >= 64'sd0)
			return $signed({1'b0, x[63:32]});
		return 33'sd0 - $signed({1'b0, m[63:32]});
	endfunction

	function automatic logic [5:0] shamt(input logic signed [63:0] x);
		logic signed [32:0] v;
		v = int_part(x);
		if (v < 33'sd0)
			return 6'd0;
		if (v > 33'sd63)
			return 6'd63;
		return v[5:0];
	endfunction

	// Left shift by s plus the 32 fraction bits, saturating.
	function automatic logic signed [63:0] shl_q(input logic signed [32:0] v,
			input logic [5:0] s);
		logic signed [95:0] w;
		w = 96'(v) <<< s;
		if (w[95:31] == '0 || w[95:31] == '1)
			return {w[31:0], 32'd0};
		return v[32] ? IRA_MIN : IRA_MAX;
	endfunction

	function automatic logic signed [63:0] ashr_q(input logic signed [32:0] v,
			input logic [5:0] s);
		logic signed [32:0] w;
		w = v >>> s;
		return {w[31:0], 32'd0};
	endfunction

	function automatic logic [63:0] umag(input logic signed [63:0] x);
		return x[63] ? 64'd0 - x : x;
	endfunction

	// Pipeline handshake.
	logic              v_q [IRA_NSTG:1];
	logic [IRA_NSTG+1:1] en;

	always_comb begin
		en[IRA_NSTG+1] = m_tready;
		for (int k = IRA_NSTG; k >= 1; k--)
			en[k] = !v_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= IRA_NSTG; k++)
				v_q[k] <= 1'b0;
		end else begin
			if (en[1])
				v_q[1] <= s_tvalid;
			for (int k = 2; k <= IRA_NSTG; k++)
				if (en[k])
					v_q[k] <= v_q[k-1];
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = v_q[IRA_NSTG];

	// Configuration.
	logic [15:0] div_eps_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_eps_q <= IRA_EPS_RESET;
		end else if (cfg_valid) begin
			div_eps_q <= cfg_data;
		end
	end

	// Stage 1: input register.
	logic [IRA_CMD_W-1:0] cmd_s1;
	logic signed [63:0]   al_s1, ah_s1, bl_s1, bh_s1;
	logic                 same_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cmd_s1  <= s_tdata[3:0];
			al_s1   <= s_tdata[67:4];
			ah_s1   <= s_tdata[131:68];
			bl_s1   <= s_tdata[195:132];
			bh_s1   <= s_tdata[259:196];
			same_s1 <= s_tuser;
		end
	end

	// Stage 1 to 2: simple ops, multiplier operands, divisor nudge.
	logic signed [63:0] side_lo, side_hi;
	logic [1:0]         tri_c, t_eq;
	logic               is_cmp;
	logic signed [32:0] vl, vh;
	logic [5:0]         sh_min, sh_max;
	logic signed [63:0] mul_x [IRA_CORNERS];
	logic signed [63:0] mul_y [IRA_CORNERS];
	logic signed [63:0] eps, nl, nh;
	logic signed [63:0] num [IRA_CORNERS];
	logic signed [63:0] den [IRA_CORNERS];

	always_comb begin
		vl     = int_part(al_s1);
		vh     = int_part(ah_s1);
		sh_min = shamt(bl_s1);
		sh_max = shamt(bh_s1);
		if (al_s1 == ah_s1 && bl_s1 == bh_s1 && al_s1 == bl_s1)
			t_eq = TRI_ALWAYS;
		else if (ah_s1 < bl_s1 || bh_s1 < al_s1)
			t_eq = TRI_NEVER;
		else
			t_eq = TRI_MAYBE;

		side_lo = IRA_MIN;
		side_hi = IRA_MAX;
		tri_c   = TRI_MAYBE;
		is_cmp  = 1'b0;
		case (cmd_s1)
			CMD_ADD: begin
				side_lo = sat_s128(128'(al_s1) + 128'(bl_s1));
				side_hi = sat_s128(128'(ah_s1) + 128'(bh_s1));
			end
			CMD_SUB: begin
				side_lo = sat_s128(128'(al_s1) - 128'(bh_s1));
				side_hi = sat_s128(128'(ah_s1) - 128'(bl_s1));
			end
			CMD_REM: begin
				side_lo = rem_min(al_s1, ah_s1, bl_s1, bh_s1);
				side_hi = rem_max(al_s1, ah_s1, bl_s1, bh_s1);
			end
			CMD_SHL: begin
				side_lo = shl_q(vl, vl[32] ? sh_max : sh_min);
				side_hi = shl_q(vh, vh[32] ? sh_min : sh_max);
			end
			CMD_ASHR: begin
				side_lo = ashr_q(vl, (vl > 33'sd0) ? sh_max : sh_min);
				side_hi = ashr_q(vh, (vh > 33'sd0) ? sh_min : sh_max);
			end
			CMD_NEG: begin
				side_lo = sneg(ah_s1);
				side_hi = sneg(al_s1);
			end
			CMD_EQ: begin
				is_cmp = 1'b1;
				tri_c  = t_eq;
			end
			CMD_NE: begin
				is_cmp = 1'b1;
				case (t_eq)
					TRI_ALWAYS: tri_c = TRI_NEVER;
					TRI_NEVER:  tri_c = TRI_ALWAYS;
					default:    tri_c = TRI_MAYBE;
				endcase
			end
			CMD_GT: begin
				is_cmp = 1'b1;
				tri_c  = (al_s1 > bh_s1) ? TRI_ALWAYS :
					((ah_s1 <= bl_s1) ? TRI_NEVER : TRI_MAYBE);
			end
			CMD_GE: begin
				is_cmp = 1'b1;
				tri_c  = (al_s1 >= bh_s1) ? TRI_ALWAYS :
					((ah_s1 < bl_s1) ? TRI_NEVER : TRI_MAYBE);
			end
			CMD_LT: begin
				is_cmp = 1'b1;
				tri_c  = (ah_s1 < bl_s1) ? TRI_ALWAYS :
					((al_s1 >= bh_s1) ? TRI_NEVER : TRI_MAYBE);
			end
			CMD_LE: begin
				is_cmp = 1'b1;
				tri_c  = (ah_s1 <= bl_s1) ? TRI_ALWAYS :
					((al_s1 > bh_s1) ? TRI_NEVER : TRI_MAYBE);
			end
			default: begin
			end
		endcase
		if (is_cmp) begin
			side_lo = (tri_c == TRI_ALWAYS) ? IRA_ONE : 64'sd0;
			side_hi = (tri_c == TRI_NEVER) ? 64'sd0 : IRA_ONE;
		end

		// The square rule reuses the first two corners as a_lo^2 and a_hi^2.
		mul_x[0] = al_s1;
		mul_y[0] = same_s1 ? al_s1 : bl_s1;
		mul_x[1] = ah_s1;
		mul_y[1] = same_s1 ? ah_s1 : bh_s1;
		mul_x[2] = al_s1;
		mul_y[2] = bh_s1;
		mul_x[3] = ah_s1;
		mul_y[3] = bl_s1;

		eps = (div_eps_q == 16'd0) ? 64'sd1 : $signed({48'd0, div_eps_q});
		if (bh_s1 <= 64'sd0) begin
			nl = smin(bl_s1, -eps);
			nh = smin(bh_s1, -eps);
		end else if (bl_s1 < 64'sd0) begin
			nl = -eps;
			nh = eps;
		end else begin
			nl = smax(bl_s1, eps);
			nh = smax(bh_s1, eps);
		end
		num[0] = al_s1;
		den[0] = nl;
		num[1] = ah_s1;
		den[1] = nh;
		num[2] = al_s1;
		den[2] = nh;
		num[3] = ah_s1;
		den[3] = nl;
	end

	// Stage 2.
	logic [IRA_CMD_W-1:0] cmd_s2;
	logic signed [63:0]   side_lo_s2, side_hi_s2;
	logic [63:0]          mx_s2 [IRA_CORNERS];
	logic [63:0]          my_s2 [IRA_CORNERS];
	logic                 mneg_s2 [IRA_CORNERS];
	logic                 same_s2, strad_s2;
	div_op_t              dop_s2 [IRA_CORNERS];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			cmd_s2     <= cmd_s1;
			side_lo_s2 <= side_lo;
			side_hi_s2 <= side_hi;
			same_s2    <= same_s1;
			strad_s2   <= (al_s1 <= 64'sd0) && (ah_s1 >= 64'sd0);
			for (int c = 0; c < IRA_CORNERS; c++) begin
				mx_s2[c]      <= umag(mul_x[c]);
				my_s2[c]      <= umag(mul_y[c]);
				mneg_s2[c]    <= mul_x[c][63] != mul_y[c][63];
				dop_s2[c].un  <= umag(num[c]);
				dop_s2[c].ud  <= umag(den[c]);
				dop_s2[c].neg <= num[c][63] != den[c][63];
			end
		end
	end

	// Stage 3: 32x32 partial products.
	logic [63:0] pp_s3 [IRA_CORNERS][4];
	logic        mneg_s3 [IRA_CORNERS];
	logic        same_s3, strad_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			same_s3  <= same_s2;
			strad_s3 <= strad_s2;
			for (int c = 0; c < IRA_CORNERS; c++) begin
				pp_s3[c][0] <= 64'(mx_s2[c][31:0])  * 64'(my_s2[c][31:0]);
				pp_s3[c][1] <= 64'(mx_s2[c][31:0])  * 64'(my_s2[c][63:32]);
				pp_s3[c][2] <= 64'(mx_s2[c][63:32]) * 64'(my_s2[c][31:0]);
				pp_s3[c][3] <= 64'(mx_s2[c][63:32]) * 64'(my_s2[c][63:32]);
				mneg_s3[c]  <= mneg_s2[c];
			end
		end
	end

	// Stage 4: magnitude of each corner product.
	logic [127:0] pmag_s4 [IRA_CORNERS];
	logic         mneg_s4 [IRA_CORNERS];
	logic         same_s4, strad_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			same_s4  <= same_s3;
			strad_s4 <= strad_s3;
			for (int c = 0; c < IRA_CORNERS; c++) begin
				pmag_s4[c] <= {64'd0, pp_s3[c][0]} + {32'd0, pp_s3[c][1], 32'd0}
					+ {32'd0, pp_s3[c][2], 32'd0} + {pp_s3[c][3], 64'd0};
				mneg_s4[c] <= mneg_s3[c];
			end
		end
	end

	// Stage 5: signed products.
	logic signed [127:0] prod_s5 [IRA_CORNERS];
	logic                same_s5, strad_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			same_s5  <= same_s4;
			strad_s5 <= strad_s4;
			for (int c = 0; c < IRA_CORNERS; c++)
				prod_s5[c] <= mneg_s4[c] ? 128'd0 - pmag_s4[c] : pmag_s4[c];
		end
	end

	// Stage 6: pairwise extremes.
	logic signed [127:0] mn01_s6, mx01_s6, mn23_s6, mx23_s6;
	logic                same_s6, strad_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			same_s6  <= same_s5;
			strad_s6 <= strad_s5;
			mn01_s6  <= (prod_s5[1] < prod_s5[0]) ? prod_s5[1] : prod_s5[0];
			mx01_s6  <= (prod_s5[1] > prod_s5[0]) ? prod_s5[1] : prod_s5[0];
			mn23_s6  <= (prod_s5[3] < prod_s5[2]) ? prod_s5[3] : prod_s5[2];
			mx23_s6  <= (prod_s5[3] > prod_s5[2]) ? prod_s5[3] : prod_s5[2];
		end
	end

	// Stage 7: product bounds; a square that straddles zero bottoms out at zero.
	logic signed [127:0] pmn_s7, pmx_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			if (same_s6) begin
				pmn_s7 <= strad_s6 ? 128'sd0 : mn01_s6;
				pmx_s7 <= mx01_s6;
			end else begin
				pmn_s7 <= (mn23_s6 < mn01_s6) ? mn23_s6 : mn01_s6;
				pmx_s7 <= (mx23_s6 > mx01_s6) ? mx23_s6 : mx01_s6;
			end
		end
	end

	logic signed [127:0] pmx_up;
	assign pmx_up = pmx_s7 + 128'sh0000_0000_FFFF_FFFF;

	// Side path: opcode and non-divide result travel alongside the divider.
	logic [IRA_CMD_W-1:0] cmd_sk    [IRA_DIV_FIRST:IRA_NSTG-1];
	logic signed [63:0]   side_lo_sk [IRA_DIV_FIRST:IRA_NSTG-1];
	logic signed [63:0]   side_hi_sk [IRA_DIV_FIRST:IRA_NSTG-1];

	for (genvar gk = IRA_DIV_FIRST; gk < IRA_NSTG; gk++) begin : g_side
		if (gk == IRA_DIV_FIRST) begin : g_head
			always_ff @(posedge clk) begin
				if (en[gk]) begin
					cmd_sk[gk]     <= cmd_s2;
					side_lo_sk[gk] <= side_lo_s2;
					side_hi_sk[gk] <= side_hi_s2;
				end
			end
		end else if (gk == IRA_MUL_DONE) begin : g_mul
			always_ff @(posedge clk) begin
				if (en[gk]) begin
					cmd_sk[gk] <= cmd_sk[gk-1];
					if (cmd_sk[gk-1] == CMD_MUL) begin
						side_lo_sk[gk] <= sat_s128(pmn_s7 >>> 32);
						side_hi_sk[gk] <= sat_s128(pmx_up >>> 32);
					end else begin
						side_lo_sk[gk] <= side_lo_sk[gk-1];
						side_hi_sk[gk] <= side_hi_sk[gk-1];
					end
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (en[gk]) begin
					cmd_sk[gk]     <= cmd_sk[gk-1];
					side_lo_sk[gk] <= side_lo_sk[gk-1];
					side_hi_sk[gk] <= side_hi_sk[gk-1];
				end
			end
		end
	end

	div_bnd_t dbnd [IRA_CORNERS];

	ira_div u_div (
		.clk     (clk),
		.en      (en[IRA_NSTG-1:IRA_DIV_FIRST]),
		.op_in   (dop_s2),
		.bnd_out (dbnd)
	);

	// Output stage.
	logic signed [63:0] dlo01, dlo23, dhi01, dhi23;
	logic signed [63:0] res_lo_s52, res_hi_s52;

	always_comb begin
		dlo01 = smin(dbnd[0].lo, dbnd[1].lo);
		dlo23 = smin(dbnd[2].lo, dbnd[3].lo);
		dhi01 = smax(dbnd[0].hi, dbnd[1].hi);
		dhi23 = smax(dbnd[2].hi, dbnd[3].hi);
	end

	always_ff @(posedge clk) begin
		if (en[IRA_NSTG]) begin
			if (cmd_sk[IRA_NSTG-1] == CMD_DIV) begin
				res_lo_s52 <= smin(dlo01, dlo23);
				res_hi_s52 <= smax(dhi01, dhi23);
			end else begin
				res_lo_s52 <= side_lo_sk[IRA_NSTG-1];
				res_hi_s52 <= side_hi_sk[IRA_NSTG-1];
			end
		end
	end

	assign m_tdata = {res_hi_s52, res_lo_s52};

endmodule

[tb/interval_range_alu_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the interval range ALU: drives operand
// intervals and opcodes, predicts each bound interval and checks every result.
// Depends on ira_pkg and the interval_range_alu top level.
module interval_range_alu_tb;
	import ira_pkg::*;

	typedef struct {
		logic signed [63:0] lo;
		logic signed [63:0] hi;
	} bounds_t;

	localparam int EXP_DEPTH = 256;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [15:0]  cfg_data = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [263:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;

	// Expected results wait in a ring, written on input beats, read on output beats.
	bounds_t exp_mem [EXP_DEPTH];
	int exp_wr = 0;
	int exp_rd = 0;
	logic [15:0] eps_shadow = IRA_EPS_RESET;
	int idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;

	interval_range_alu dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	// Prediction helpers; the wide math runs on 130-bit signed values so nothing wraps.
	function automatic logic signed [63:0] sat130(input logic signed [129:0] v);
		if (v > 130'sd9223372036854775807)
			return IRA_MAX;
		if (v < -130'sd9223372036854775808)
			return IRA_MIN;
		return v[63:0];
	endfunction

	function automatic logic signed [63:0] neg_sat(input logic signed [63:0] x);
		return (x == IRA_MIN) ? IRA_MAX : -x;
	endfunction

	function automatic logic signed [63:0] min64(input logic signed [63:0] x, y);
		return x < y ? x : y;
	endfunction

	function automatic logic signed [63:0] max64(input logic signed [63:0] x, y);
		return x > y ? x : y;
	endfunction

	// Arithmetic shift of a 130-bit value by 32 floors toward minus infinity.
	function automatic logic signed [129:0] floor_q(input logic signed [129:0] p);
		return p >>> 32;
	endfunction

	function automatic logic signed [129:0] ceil_q(input logic signed [129:0] p);
		return (p + 130'sh0_FFFF_FFFF) >>> 32;
	endfunction

	// Quotient of two Q32.32 values in Q32.32, rounded down or up.
	function automatic logic signed [129:0] quot_q(input logic signed [63:0] n, d,
			input bit up);
		logic signed [129:0] num, den, q, r;
		num = 130'(n) <<< 32;
		den = 130'(d);
		if (den == 0)
			return '0;
		q = num / den;
		r = num - q * den;
		if (r != 0) begin
			if ((num < 0) != (den < 0)) begin
				if (!up)
					q = q - 1;
			end else if (up) begin
				q = q + 1;
			end
		end
		return q;
	endfunction

	function automatic logic signed [63:0] int_of(input logic signed [63:0] x);
		logic signed [63:0] m;
		if (x >= 0)
			return x >>> 32;
		m = -x;
		return -($unsigned(m) >> 32);
	endfunction

	function automatic int shift_count(input logic signed [63:0] x);
		logic signed [63:0] v;
		v = int_of(x);
		if (v < 0)
			return 0;
		if (v > 63)
			return 63;
		return int'(v);
	endfunction

	function automatic logic signed [63:0] shl_clip(input logic signed [63:0] v, input int k);
		logic signed [129:0] w;
		if (v == 0)
			return '0;
		if (k >= 64)
			return v < 0 ? IRA_MIN : IRA_MAX;
		w = 130'(v) <<< k;
		return sat130(w);
	endfunction

	function automatic logic signed [63:0] rem_upper(input logic signed [63:0] al, ah, bl, bh);
		if (al >= 0)
			return ah >= bh ? sat130(130'(bh) - 130'(IRA_ONE)) : ah;
		if (ah < 0)
			return neg_sat(rem_lower(neg_sat(ah), neg_sat(al), bl, bh));
		return rem_upper(0, ah, bl, bh);
	endfunction

	function automatic logic signed [63:0] rem_lower(input logic signed [63:0] al, ah, bl, bh);
		if (bh < 0 && bl < 0)
			return rem_lower(al, ah, neg_sat(bh), neg_sat(bl));
		if (bl < 0)
			return min64(rem_lower(al, ah, IRA_ONE, neg_sat(bl)), rem_lower(al, ah, 0, bh));
		if (al >= 0) begin
			if (al == 0 || ah == 0)
				return '0;
			if (ah >= bl && al <= bh)
				return '0;
			if (ah < bl)
				return al;
			return '0;
		end
		if (ah < 0)
			return neg_sat(rem_upper(neg_sat(ah), neg_sat(al), bl, bh));
		return min64(neg_sat(rem_upper(IRA_ONE, neg_sat(al), bl, bh)),
			rem_lower(0, ah, bl, bh));
	endfunction

	function automatic bounds_t predict_bounds(input logic [3:0] cmd,
			input logic signed [63:0] al, ah, bl, bh, input bit same);
		bounds_t r;
		logic signed [129:0] p[4];
		logic signed [129:0] mn, mx, f, c;
		logic signed [63:0] e, nl, nh, vl, vh;
		int smin, smax, tri_v;
		r.lo = IRA_MIN;
		r.hi = IRA_MAX;
		tri_v = -1;
		case (cmd)
			CMD_ADD: begin
				r.lo = sat130(130'(al) + 130'(bl));
				r.hi = sat130(130'(ah) + 130'(bh));
			end
			CMD_SUB: begin
				r.lo = sat130(130'(al) - 130'(bh));
				r.hi = sat130(130'(ah) - 130'(bl));
			end
			CMD_MUL: begin
				if (same) begin
					f = 130'(al) * 130'(al);
					c = 130'(ah) * 130'(ah);
					mx = f < c ? c : f;
					mn = (al <= 0 && ah >= 0) ? 130'sd0 : (f < c ? f : c);
				end else begin
					p[0] = 130'(al) * 130'(bl);
					p[1] = 130'(ah) * 130'(bh);
					p[2] = 130'(al) * 130'(bh);
					p[3] = 130'(ah) * 130'(bl);
					mn = p[0];
					mx = p[0];
					for (int i = 1; i < 4; i++) begin
						if (p[i] < mn) mn = p[i];
						if (p[i] > mx) mx = p[i];
					end
				end
				r.lo = sat130(floor_q(mn));
				r.hi = sat130(ceil_q(mx));
			end
			CMD_DIV: begin
				e = (eps_shadow == 0) ? 64'sd1 : 64'(eps_shadow);
				nl = bl;
				nh = bh;
				if (nh <= 0) begin
					nl = min64(nl, -e);
					nh = min64(nh, -e);
				end else if (nl < 0) begin
					nl = -e;
					nh = e;
				end else begin
					nl = max64(nl, e);
					nh = max64(nh, e);
				end
				mn = quot_q(al, nl, 0);
				mx = quot_q(al, nl, 1);
				f = quot_q(ah, nh, 0); c = quot_q(ah, nh, 1);
				if (f < mn) mn = f;
				if (c > mx) mx = c;
				f = quot_q(al, nh, 0); c = quot_q(al, nh, 1);
				if (f < mn) mn = f;
				if (c > mx) mx = c;
				f = quot_q(ah, nl, 0); c = quot_q(ah, nl, 1);
				if (f < mn) mn = f;
				if (c > mx) mx = c;
				r.lo = sat130(mn);
				r.hi = sat130(mx);
			end
			CMD_REM: begin
				r.lo = rem_lower(al, ah, bl, bh);
				r.hi = rem_upper(al, ah, bl, bh);
			end
			CMD_SHL: begin
				smin = shift_count(bl);
				smax = shift_count(bh);
				vl = int_of(al);
				vh = int_of(ah);
				r.lo = shl_clip(vl, (vl < 0 ? smax : smin) + 32);
				r.hi = shl_clip(vh, (vh < 0 ? smin : smax) + 32);
			end
			CMD_ASHR: begin
				smin = shift_count(bl);
				smax = shift_count(bh);
				vl = int_of(al);
				vh = int_of(ah);
				r.lo = (vl >>> (vl > 0 ? smax : smin)) <<< 32;
				r.hi = (vh >>> (vh > 0 ? smin : smax)) <<< 32;
			end
			CMD_NEG: begin
				r.lo = neg_sat(ah);
				r.hi = neg_sat(al);
			end
			CMD_EQ, CMD_NE: begin
				tri_v = (al == ah && bl == bh && al == bl) ? 1 : ((ah < bl || bh < al) ? 0 : 2);
				if (cmd == CMD_NE && tri_v != 2)
					tri_v = 1 - tri_v;
			end
			CMD_GT: tri_v = al > bh ? 1 : (ah <= bl ? 0 : 2);
			CMD_GE: tri_v = al >= bh ? 1 : (ah < bl ? 0 : 2);
			CMD_LT: tri_v = ah < bl ? 1 : (al >= bh ? 0 : 2);
			CMD_LE: tri_v = ah <= bl ? 1 : (al > bh ? 0 : 2);
			default: ;
		endcase
		if (tri_v >= 0) begin
			r.lo = tri_v == 1 ? IRA_ONE : 64'sd0;
			r.hi = tri_v == 0 ? 64'sd0 : IRA_ONE;
		end
		return r;
	endfunction

	// Result checker and receiver stall generator.
	always @(posedge clk) begin
		bounds_t want;
		logic signed [63:0] got_lo, got_hi;
		if (m_tvalid && m_tready) begin
			got_lo = m_tdata[63:0];
			got_hi = m_tdata[127:64];
			results_seen++;
			if (exp_wr == exp_rd) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat lo=%h hi=%h", got_lo, got_hi);
			end else begin
				want = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (got_lo !== want.lo || got_hi !== want.hi) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected [%h,%h] got [%h,%h]",
							want.lo, want.hi, got_lo, got_hi);
				end
			end
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// The valid line stays high between back-to-back beats and drops only while idling.
	task automatic send_item(input logic [3:0] cmd, input logic signed [63:0] al, ah, bl, bh,
			input bit same);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= {4'd0, bh, bl, ah, al, cmd};
		s_tuser <= same;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		exp_mem[exp_wr % EXP_DEPTH] = predict_bounds(cmd, al, ah, bl, bh, same);
		exp_wr++;
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		while (exp_wr != exp_rd)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_epsilon(input logic [15:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		eps_shadow = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [63:0] rand_bound();
		logic signed [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(7))
			0: v = IRA_MIN + $urandom_range(3);
			1: v = IRA_MAX - $urandom_range(3);
			2: v = $signed(64'($urandom_range(20))) - 10;
			3: v = v >>> $urandom_range(63);
			4: v = ($signed(64'($urandom_range(40))) - 20) <<< 32;
			default: ;
		endcase
		return v;
	endfunction

	task automatic test_directed();
		logic signed [63:0] one, big;
		one = IRA_ONE;
		big = IRA_MAX;
		for (int c = 0; c < 16; c++)
			send_item(c[3:0], -3 * one, 5 * one, -2 * one, 4 * one, 1'b0);
		send_item(CMD_ADD, big, big, big, big, 1'b0);
		send_item(CMD_SUB, IRA_MIN, IRA_MIN, big, big, 1'b0);
		send_item(CMD_MUL, IRA_MIN, big, IRA_MIN, big, 1'b0);
		send_item(CMD_MUL, -7 * one, 3 * one, 0, 0, 1'b1);
		send_item(CMD_DIV, one, 2 * one, 0, 0, 1'b0);
		send_item(CMD_REM, 9 * one, 2 * one, 3 * one, -one, 1'b0);
		send_item(CMD_SHL, 5 * one, big, -one, 100 * one, 1'b0);
		send_item(CMD_NEG, IRA_MIN, IRA_MIN, 0, 0, 1'b0);
		send_item(CMD_EQ, one, one, one, one, 1'b0);
	endtask

	task automatic test_random(input int count);
		logic signed [63:0] al, ah, bl, bh, t;
		logic [3:0] cmd;
		for (int i = 0; i < count; i++) begin
			al = rand_bound();
			ah = rand_bound();
			bl = rand_bound();
			bh = rand_bound();
			// Mostly ordered intervals; a few stay inverted.
			if ($urandom_range(9) != 0) begin
				if (al > ah) begin t = al; al = ah; ah = t; end
				if (bl > bh) begin t = bl; bl = bh; bh = t; end
			end
			cmd = 4'($urandom_range(15));
			send_item(cmd, al, ah, bl, bh, $urandom_range(1));
		end
	endtask

	task automatic test_epsilon_settings();
		logic [15:0] eps_list[4] = '{16'd0, 16'd1, 16'hFFFF, 16'd1000};
		foreach (eps_list[i]) begin
			drain_pipeline();
			write_epsilon(eps_list[i]);
			for (int k = 0; k < 20; k++)
				send_item(CMD_DIV, rand_bound(), rand_bound(),
					-64'sd5 + $urandom_range(10), $urandom_range(70000), 1'b0);
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(200);
		idle_pct = 48;
		test_random(200);
		idle_pct = 0;
		stall_pct = 48;
		test_random(200);
		// Hold off until the pipeline has emptied, then resume under both.
		drain_pipeline();
		idle_pct = 8;
		stall_pct = 8;
		test_random(200);
		idle_pct = 0;
		stall_pct = 0;
		test_epsilon_settings();
		test_random(120);
		drain_pipeline();
		$display("sent %0d items over all opcodes, %0d results checked, four epsilon values",
			items_sent, results_seen);
		if (mismatches == 0 && exp_wr == exp_rd)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end
endmodule
